[sv/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg - shared definitions for the fixed block pool allocator
// Field widths, register indexes, reset values and status codes.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int BYTES_W  = 16;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    // Default pool capacity
    localparam int MAX_BLOCKS_DEFAULT = 256;

    // Smallest block size that is honoured
    localparam logic [BYTES_W-1:0] MIN_BYTES = BYTES_W'(8);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    // Configuration reset values
    localparam logic [ADDR_W-1:0]  RST_BASE  = 32'h0000_1000;
    localparam logic [BYTES_W-1:0] RST_BYTES = 16'd64;
    localparam logic [COUNT_W-1:0] RST_COUNT = 9'd256;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_POOL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_BOUNDARY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

endpackage

[sv/fixed_block_pool_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator - LIFO free-list allocator for a pool of blocks
// Hands out and takes back equal-sized blocks, checking every free request.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (in_valid/in_ready, mode, address): mode 0 allocates the
//   block at the head of the free list, mode 1 returns the block at address.
//   Result channel (out_valid/out_ready, status, block_address, free_count):
//   one result per request, in request order.
//   Configuration: cfg_write with cfg_index 0 (base), 1 (block size) or
//   2 (block count) rebuilds the pool: all blocks free, listed in order.
//   Write configuration only while no request is in flight.
// Timing
//   One request is handled at a time. An allocate goes through S_ALLOC and
//   S_ALLOC_WB to S_DONE, skipping S_ALLOC_WB when the pool is empty; a free
//   goes through S_SPAN and S_RANGE, then, unless rejected by range, through
//   the 9-step bit-serial remainder unit and S_BOUND, and checks the free mark
//   in S_FREE_WB unless rejected by the boundary check or by a block never
//   handed out. Each request makes at most one read and one write of the link
//   memory. Reset rebuilds the pool at once, with no clearing pass: link
//   entries above the allocation high-water mark read as their initial value.
//   A stalled result waits in the output register while the next request is
//   taken and worked on; that one then waits until the register is free.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
)(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [ADDR_W-1:0]    address,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [ADDR_W-1:0]    block_address,
    output logic [COUNT_W-1:0]   free_count,
    // configuration
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int AW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int WORD_W = COUNT_W + 1;
    localparam int PROD_W = BYTES_W + COUNT_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ALLOC    = 4'd1;
    localparam logic [3:0] S_ALLOC_WB = 4'd2;
    localparam logic [3:0] S_SPAN     = 4'd3;
    localparam logic [3:0] S_RANGE    = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_BOUND    = 4'd6;
    localparam logic [3:0] S_FREE_WB  = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    // Clamp a block count to the range the pool supports
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] r;
        r = c;
        if (c == '0)
            r = COUNT_W'(1);
        else if (int'(c) > MAX_BLOCKS)
            r = COUNT_W'(MAX_BLOCKS);
        return r;
    endfunction

    // Configuration registers
    logic [ADDR_W-1:0]   base_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [COUNT_W-1:0]  count_reg;

    // Free-list control state
    logic [3:0]          state_reg;
    logic [COUNT_W-1:0]  head_reg;
    logic [COUNT_W-1:0]  total_reg;
    logic [COUNT_W-1:0]  fresh_reg;

    // Request and working registers
    logic                mode_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ADDR_W:0]     off_reg;
    logic [BYTES_W-1:0]  rem_reg;
    logic [COUNT_W-1:0]  dq_reg;
    logic [3:0]          div_cnt_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [ADDR_W-1:0]   res_addr_reg;

    // Output register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ADDR_W-1:0]   block_address_reg;
    logic [COUNT_W-1:0]  free_count_reg;

    // Link memory: {free mark, next link}
    logic [WORD_W-1:0]   link_mem [MAX_BLOCKS];
    logic [WORD_W-1:0]   rd_data_reg;
    logic                mem_rd;
    logic [AW-1:0]       mem_rd_addr;
    logic                mem_wr;
    logic [AW-1:0]       mem_wr_addr;
    logic [WORD_W-1:0]   mem_wr_data;

    // Derived values
    logic [COUNT_W-1:0]  n_eff;
    logic [BYTES_W-1:0]  bytes_eff;
    logic                pool_empty;
    logic                in_xfer;
    logic                slot_free;
    logic                cfg_hit;
    logic [COUNT_W-1:0]  count_next;
    logic [COUNT_W-1:0]  mul_a;
    logic [COUNT_W:0]    head_inc;
    logic [COUNT_W-1:0]  implied_link;
    logic [COUNT_W-1:0]  head_link;
    logic [ADDR_W:0]     pool_end;
    logic                not_in_pool;
    logic [BYTES_W:0]    trial;
    logic                trial_ge;

    assign n_eff      = clamp_count(count_reg);
    assign bytes_eff  = (bytes_reg < MIN_BYTES) ? MIN_BYTES : bytes_reg;
    assign pool_empty = (total_reg == '0) || (head_reg >= n_eff);
    assign in_ready   = (state_reg == S_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;

    // Rebuild on a write to a known register
    assign cfg_hit    = cfg_write && ((cfg_index == CFG_BASE) || (cfg_index == CFG_BYTES)
                                      || (cfg_index == CFG_COUNT));
    assign count_next = (cfg_write && cfg_index == CFG_COUNT) ? cfg_data[COUNT_W-1:0]
                                                              : count_reg;

    // Shared multiplier operand: head for allocate, pool size for free
    assign mul_a = (state_reg == S_ALLOC) ? head_reg : n_eff;

    // Initial link of the head entry, used above the high-water mark
    assign head_inc     = {1'b0, head_reg} + (COUNT_W+1)'(1);
    assign implied_link = (head_inc < {1'b0, n_eff}) ? head_inc[COUNT_W-1:0] : n_eff;
    assign head_link    = (head_reg < fresh_reg) ? rd_data_reg[COUNT_W-1:0] : implied_link;

    // Pool range check
    assign pool_end    = {1'b0, base_reg} + (ADDR_W+1)'(prod_reg);
    assign not_in_pool = (addr_reg == '0) || off_reg[ADDR_W]
                         || ({1'b0, addr_reg} >= pool_end);

    // Remainder step: shift in one offset bit, subtract when it fits
    assign trial    = {rem_reg, dq_reg[COUNT_W-1]};
    assign trial_ge = (trial >= {1'b0, bytes_eff});

    // Memory port control
    assign mem_rd      = ((state_reg == S_ALLOC) && !pool_empty)
                         || ((state_reg == S_BOUND) && (rem_reg == '0)
                             && (dq_reg < fresh_reg));
    assign mem_rd_addr = (state_reg == S_ALLOC) ? AW'(head_reg) : AW'(dq_reg);
    assign mem_wr      = (state_reg == S_ALLOC_WB)
                         || ((state_reg == S_FREE_WB) && !rd_data_reg[COUNT_W]);
    assign mem_wr_addr = (state_reg == S_ALLOC_WB) ? AW'(head_reg) : AW'(dq_reg);
    assign mem_wr_data = (state_reg == S_ALLOC_WB) ? {1'b0, {COUNT_W{1'b0}}}
                       : {1'b1, (total_reg == '0) ? n_eff : head_reg};

    // Link memory, one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            link_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd)
        begin
            rd_data_reg <= link_mem[mem_rd_addr];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= RST_BASE;
            bytes_reg <= RST_BYTES;
            count_reg <= RST_COUNT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BASE:  base_reg  <= cfg_data;
                CFG_BYTES: bytes_reg <= cfg_data[BYTES_W-1:0];
                CFG_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Sequencer and free-list state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            total_reg   <= clamp_count(RST_COUNT);
            fresh_reg   <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_hit)
                    begin
                        head_reg  <= '0;
                        total_reg <= clamp_count(count_next);
                        fresh_reg <= '0;
                    end
                    if (in_xfer)
                    begin
                        state_reg <= mode ? S_SPAN : S_ALLOC;
                    end
                end
                S_ALLOC:
                begin
                    state_reg <= pool_empty ? S_DONE : S_ALLOC_WB;
                end
                S_ALLOC_WB:
                begin
                    // pop the head, advancing the high-water mark when the head is at it
                    head_reg  <= head_link;
                    total_reg <= total_reg - COUNT_W'(1);
                    if (head_reg == fresh_reg)
                    begin
                        fresh_reg <= fresh_reg + COUNT_W'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_SPAN:
                begin
                    state_reg <= S_RANGE;
                end
                S_RANGE:
                begin
                    div_cnt_reg <= 4'(COUNT_W);
                    state_reg   <= not_in_pool ? S_DONE : S_DIV;
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg - 4'd1;
                    if (div_cnt_reg == 4'd1)
                    begin
                        state_reg <= S_BOUND;
                    end
                end
                S_BOUND:
                begin
                    state_reg <= mem_rd ? S_FREE_WB : S_DONE;
                end
                S_FREE_WB:
                begin
                    // push the block at the head unless it is already free
                    if (!rd_data_reg[COUNT_W])
                    begin
                        head_reg  <= dq_reg;
                        total_reg <= total_reg + COUNT_W'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Working registers and result staging
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    mode_reg <= mode;
                    addr_reg <= address;
                end
            end
            S_ALLOC:
            begin
                prod_reg       <= PROD_W'(mul_a) * PROD_W'(bytes_eff);
                res_status_reg <= pool_empty ? ST_EMPTY : ST_OK;
                res_addr_reg   <= '0;
            end
            S_ALLOC_WB:
            begin
                res_addr_reg <= base_reg + ADDR_W'(prod_reg);
            end
            S_SPAN:
            begin
                prod_reg <= PROD_W'(mul_a) * PROD_W'(bytes_eff);
                off_reg  <= {1'b0, addr_reg} - {1'b0, base_reg};
            end
            S_RANGE:
            begin
                // offset is below size * 2^9 here, so its top part fits one block
                rem_reg        <= off_reg[COUNT_W+BYTES_W-1:COUNT_W];
                dq_reg         <= off_reg[COUNT_W-1:0];
                res_status_reg <= ST_NOT_IN_POOL;
                res_addr_reg   <= '0;
            end
            S_DIV:
            begin
                if (trial_ge)
                begin
                    rem_reg <= BYTES_W'(trial - {1'b0, bytes_eff});
                end
                else
                begin
                    rem_reg <= trial[BYTES_W-1:0];
                end
                dq_reg <= {dq_reg[COUNT_W-2:0], trial_ge};
            end
            S_BOUND:
            begin
                if (rem_reg != '0)
                begin
                    res_status_reg <= ST_NOT_BOUNDARY;
                end
                else if (!mem_rd)
                begin
                    res_status_reg <= ST_ALREADY_FREE;
                end
            end
            S_FREE_WB:
            begin
                res_status_reg <= rd_data_reg[COUNT_W] ? ST_ALREADY_FREE : ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    // Output register: load when the slot is free, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_DONE) && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && slot_free)
        begin
            status_reg        <= res_status_reg;
            block_address_reg <= mode_reg ? '0 : res_addr_reg;
            free_count_reg    <= total_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign block_address = block_address_reg;
    assign free_count    = free_count_reg;

    // Free count never exceeds the pool size
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= n_eff)
        else $error("free count above pool size");

    // High-water mark stays inside the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= n_eff)
        else $error("high-water mark beyond pool");

    // An exhausted list ends on the null link
    assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg == '0) |-> (head_reg == n_eff))
        else $error("empty list with live head");

    // Only a successful allocate carries an address
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (block_address_reg == '0))
        else $error("address on a failed request");

    // A write-back follows the read of the same request
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |-> ($past(state_reg) == S_ALLOC || $past(state_reg) == S_BOUND))
        else $error("memory write without a preceding read");

endmodule
